// ===== rtl/core/fpct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpct_pkg
// Types, command codes and sizes shared by the frustum plane cull test core.
// ----------------------------------------------------------------------------
package fpct_pkg;

  localparam int DEF_PLANE_COUNT = 6;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int FRAC_BITS       = 16;
  // distance accumulator wraps like the 64-bit sum it models
  localparam int ACC_BITS        = 64;
  // bias accumulator holds the exact extent sum or radius term plus sign
  localparam int BIAS_BITS       = 66;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;
  localparam logic [1:0] CMD_BOX    = 2'd3;

  // product terms per plane: x, y, z of the dot product, then x, y, z extents
  localparam logic [2:0] TERM_X     = 3'd0;
  localparam logic [2:0] TERM_Y     = 3'd1;
  localparam logic [2:0] TERM_Z     = 3'd2;
  localparam logic [2:0] TERM_EX    = 3'd3;
  localparam logic [2:0] TERM_EY    = 3'd4;
  localparam logic [2:0] TERM_EZ    = 3'd5;
  localparam logic [2:0] TERMS_DOT  = 3'd3;
  localparam logic [2:0] TERMS_BOX  = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         plane_slot;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] scalar_w;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } in_word_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] test_kind;
  } out_word_t;

  typedef struct packed {
    logic       init;      // load offset and bias at the start of a plane
    logic       sphere;    // bias starts from the radius term
    logic       issue;     // start a product this cycle
    logic [2:0] term;      // which product to start
    logic       acc;       // add last product into an accumulator
    logic       acc_bias;  // that product is an extent term
  } mac_ctrl_t;

endpackage

// ===== rtl/core/fpct_plane_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpct_plane_regs
// Plane table: normal and offset per plane, one write and one read port.
// ----------------------------------------------------------------------------
module fpct_plane_regs #(
  parameter int PLANE_COUNT = fpct_pkg::DEF_PLANE_COUNT,
  parameter int VALUE_BITS  = fpct_pkg::DEF_VALUE_BITS,
  localparam int IDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [2:0]                   wr_slot,
  input  logic signed [VALUE_BITS-1:0] wr_nx,
  input  logic signed [VALUE_BITS-1:0] wr_ny,
  input  logic signed [VALUE_BITS-1:0] wr_nz,
  input  logic signed [VALUE_BITS-1:0] wr_off,
  input  logic [IDX_W-1:0]             rd_idx,
  output logic signed [VALUE_BITS-1:0] rd_nx,
  output logic signed [VALUE_BITS-1:0] rd_ny,
  output logic signed [VALUE_BITS-1:0] rd_nz,
  output logic signed [VALUE_BITS-1:0] rd_off
);

  logic signed [VALUE_BITS-1:0] nx_r  [PLANE_COUNT];
  logic signed [VALUE_BITS-1:0] ny_r  [PLANE_COUNT];
  logic signed [VALUE_BITS-1:0] nz_r  [PLANE_COUNT];
  logic signed [VALUE_BITS-1:0] off_r [PLANE_COUNT];

  logic             slot_ok;
  logic [IDX_W-1:0] wr_idx;

  // drop loads aimed past the last plane
  assign slot_ok = {2'b00, wr_slot} < 5'(PLANE_COUNT);
  assign wr_idx  = IDX_W'(wr_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PLANE_COUNT; k++) begin
        nx_r[k]  <= '0;
        ny_r[k]  <= '0;
        nz_r[k]  <= '0;
        off_r[k] <= '0;
      end
    end else if (we && slot_ok) begin
      nx_r[wr_idx]  <= wr_nx;
      ny_r[wr_idx]  <= wr_ny;
      nz_r[wr_idx]  <= wr_nz;
      off_r[wr_idx] <= wr_off;
    end
  end

  assign rd_nx  = nx_r[rd_idx];
  assign rd_ny  = ny_r[rd_idx];
  assign rd_nz  = nz_r[rd_idx];
  assign rd_off = off_r[rd_idx];

endmodule

// ===== rtl/core/fpct_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpct_mac
// Shared multiply-accumulate: one product per cycle while issue is set, into
// the distance or bias accumulator, and the final sign test per plane.
// ----------------------------------------------------------------------------
module fpct_mac #(
  parameter int VALUE_BITS = fpct_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  fpct_pkg::mac_ctrl_t          ctrl,
  input  logic signed [VALUE_BITS-1:0] nx,
  input  logic signed [VALUE_BITS-1:0] ny,
  input  logic signed [VALUE_BITS-1:0] nz,
  input  logic signed [VALUE_BITS-1:0] off,
  input  logic signed [VALUE_BITS-1:0] px,
  input  logic signed [VALUE_BITS-1:0] py,
  input  logic signed [VALUE_BITS-1:0] pz,
  input  logic signed [VALUE_BITS-1:0] w,
  input  logic [VALUE_BITS-2:0]        hx,
  input  logic [VALUE_BITS-2:0]        hy,
  input  logic [VALUE_BITS-2:0]        hz,
  output logic                         cull
);

  localparam int MW = VALUE_BITS + 1;
  localparam int PW = 2 * MW;
  localparam int AW = fpct_pkg::ACC_BITS;
  localparam int BW = fpct_pkg::BIAS_BITS;

  logic signed [MW-1:0] ax, ay, az;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] dacc;
  logic signed [BW-1:0] bias;
  logic signed [BW-1:0] total;

  assign ax = nx[VALUE_BITS-1] ? -MW'(nx) : MW'(nx);
  assign ay = ny[VALUE_BITS-1] ? -MW'(ny) : MW'(ny);
  assign az = nz[VALUE_BITS-1] ? -MW'(nz) : MW'(nz);

  always_comb begin
    case (ctrl.term)
      fpct_pkg::TERM_X: begin
        op_a = MW'(nx);
        op_b = MW'(px);
      end
      fpct_pkg::TERM_Y: begin
        op_a = MW'(ny);
        op_b = MW'(py);
      end
      fpct_pkg::TERM_Z: begin
        op_a = MW'(nz);
        op_b = MW'(pz);
      end
      fpct_pkg::TERM_EX: begin
        op_a = ax;
        op_b = signed'(MW'(hx));
      end
      fpct_pkg::TERM_EY: begin
        op_a = ay;
        op_b = signed'(MW'(hy));
      end
      fpct_pkg::TERM_EZ: begin
        op_a = az;
        op_b = signed'(MW'(hz));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod <= op_a * op_b;
    end
    if (ctrl.init) begin
      dacc <= AW'(off) <<< fpct_pkg::FRAC_BITS;
      bias <= ctrl.sphere ? (BW'(w) <<< fpct_pkg::FRAC_BITS) : '0;
    end else if (ctrl.acc) begin
      if (ctrl.acc_bias) begin
        bias <= bias + BW'(prod);
      end else begin
        dacc <= dacc + AW'(prod);
      end
    end
  end

  // culled when the wrapped distance plus bias goes negative
  assign total = BW'(dacc) + bias;
  assign cull  = total[BW-1];

endmodule

// ===== rtl/core/frustum_plane_cull_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_cull_test_unit
// Six-plane frustum cull for points, spheres and boxes in Q16.16.
//
//   channel  dir  handshake                  word
//   item     in   item_valid / item_stall    fpct_pkg::in_word_t
//   result   out  result_valid / result_stall fpct_pkg::out_word_t
//
// A load gives no result. A test runs plane by plane, one multiplier
// forming every product: three per plane for a point or sphere, six for a
// box; testing stops at the first plane that culls.
// Reset clears the plane table to zero and drops any pending result.
// item_stall is high while a test runs; a result held by result_stall
// holds the end of the next test only.
// ----------------------------------------------------------------------------
module frustum_plane_cull_test_unit #(
  parameter int PLANE_COUNT = fpct_pkg::DEF_PLANE_COUNT,
  parameter int VALUE_BITS  = fpct_pkg::DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  fpct_pkg::in_word_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output fpct_pkg::out_word_t  result
);

  localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state;
  logic [IDX_W-1:0]     plane;
  logic [2:0]           phase;
  fpct_pkg::in_word_t   cur;
  fpct_pkg::mac_ctrl_t  ctrl;

  logic                 accept;
  logic                 is_box;
  logic [2:0]           n_terms;
  logic                 at_cmp;
  logic                 last_plane;
  logic                 out_free;
  logic                 cull;
  logic                 emit;

  logic signed [VALUE_BITS-1:0] pl_nx, pl_ny, pl_nz, pl_off;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_box     = (cur.cmd == fpct_pkg::CMD_BOX);
  assign n_terms    = is_box ? fpct_pkg::TERMS_BOX : fpct_pkg::TERMS_DOT;
  assign at_cmp     = (phase == n_terms + 3'd1);
  assign last_plane = (plane == IDX_W'(PLANE_COUNT - 1));
  assign out_free   = !result_valid || !result_stall;
  assign emit       = (state == ST_RUN) && at_cmp && (cull || last_plane) && out_free;

  fpct_plane_regs #(
    .PLANE_COUNT (PLANE_COUNT),
    .VALUE_BITS  (VALUE_BITS)
  ) u_planes (
    .clk     (clk),
    .rst     (rst),
    .we      (accept && item.cmd == fpct_pkg::CMD_LOAD),
    .wr_slot (item.plane_slot),
    .wr_nx   (signed'(item.vec_x[VALUE_BITS-1:0])),
    .wr_ny   (signed'(item.vec_y[VALUE_BITS-1:0])),
    .wr_nz   (signed'(item.vec_z[VALUE_BITS-1:0])),
    .wr_off  (signed'(item.scalar_w[VALUE_BITS-1:0])),
    .rd_idx  (plane),
    .rd_nx   (pl_nx),
    .rd_ny   (pl_ny),
    .rd_nz   (pl_nz),
    .rd_off  (pl_off)
  );

  always_comb begin
    ctrl.init     = (state == ST_RUN) && (phase == 3'd0);
    ctrl.sphere   = (cur.cmd == fpct_pkg::CMD_SPHERE);
    ctrl.issue    = (state == ST_RUN) && (phase < n_terms);
    ctrl.term     = phase;
    ctrl.acc      = (state == ST_RUN) && (phase != 3'd0) && (phase <= n_terms);
    ctrl.acc_bias = (phase > fpct_pkg::TERM_EX);
  end

  fpct_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .nx   (pl_nx),
    .ny   (pl_ny),
    .nz   (pl_nz),
    .off  (pl_off),
    .px   (signed'(cur.vec_x[VALUE_BITS-1:0])),
    .py   (signed'(cur.vec_y[VALUE_BITS-1:0])),
    .pz   (signed'(cur.vec_z[VALUE_BITS-1:0])),
    .w    (signed'(cur.scalar_w[VALUE_BITS-1:0])),
    .hx   (cur.half_x[VALUE_BITS-2:0]),
    .hy   (cur.half_y[VALUE_BITS-2:0]),
    .hz   (cur.half_z[VALUE_BITS-2:0]),
    .cull (cull)
  );

  always_ff @(posedge clk) begin
    if (accept && item.cmd != fpct_pkg::CMD_LOAD) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      plane        <= '0;
      phase        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && item.cmd != fpct_pkg::CMD_LOAD) begin
            state <= ST_RUN;
            plane <= '0;
            phase <= '0;
          end
        end
        ST_RUN: begin
          if (!at_cmp) begin
            phase <= phase + 3'd1;
          end else if (cull || last_plane) begin
            // hold here until the output register frees up
            if (out_free) begin
              result.visible   <= !cull;
              result.test_kind <= cur.cmd;
              state            <= ST_IDLE;
            end
          end else begin
            plane <= plane + IDX_W'(1);
            phase <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_RUN)
    else $error("result raised without a running test");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> phase <= n_terms + 3'd1)
    else $error("phase ran past the compare step");

  a_test_starts: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd != fpct_pkg::CMD_LOAD |=> state == ST_RUN && phase == 3'd0)
    else $error("accepted test did not start");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == fpct_pkg::CMD_LOAD && !result_valid |=> !result_valid)
    else $error("load produced a result");

  a_kind_not_load: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.test_kind != fpct_pkg::CMD_LOAD)
    else $error("result carries a load code");

endmodule

// ===== dv/frustum_plane_cull_test_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_cull_test_unit_tb
// Drives plane loads and point, sphere and box tests through the cull unit in
// random bursts, predicts each visible flag from a local copy of the plane
// table, and checks every result word in order while the result side stalls.
// ----------------------------------------------------------------------------
module frustum_plane_cull_test_unit_tb;

  localparam int PLANES     = 6;
  localparam int ONE        = 65536;
  localparam int VMAX       = 32'h7fff_ffff;
  localparam int VMIN       = 32'h8000_0000;
  localparam int HMAX       = 32'h7fff_ffff;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL       = 60;

  typedef longint unsigned u64_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  fpct_pkg::in_word_t   item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  fpct_pkg::out_word_t  result;

  fpct_pkg::in_word_t   scene_q[$];
  fpct_pkg::out_word_t  visibility_q[$];
  int          plane_nx[PLANES];
  int          plane_ny[PLANES];
  int          plane_nz[PLANES];
  int          plane_off[PLANES];

  int          words_in = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  frustum_plane_cull_test_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic u64_t mag(int n);
    return (n < 0) ? u64_t'(-longint'(n)) : u64_t'(longint'(n));
  endfunction

  function automatic bit object_visible(fpct_pkg::in_word_t w);
    longint px, py, pz, d;
    u64_t   ext;
    bit     culled;
    bit     vis;
    int     k;
    px  = longint'(w.vec_x);
    py  = longint'(w.vec_y);
    pz  = longint'(w.vec_z);
    vis = 1'b1;
    for (k = 0; k < PLANES; k++) begin
      // Q32.32 distance, wraps like the 64-bit accumulator
      d = longint'(plane_nx[k]) * px + longint'(plane_ny[k]) * py
        + longint'(plane_nz[k]) * pz + longint'(plane_off[k]) * ONE;
      case (w.cmd)
        fpct_pkg::CMD_POINT:  culled = d < 0;
        fpct_pkg::CMD_SPHERE: culled = d < -(longint'(w.scalar_w) * ONE);
        default: begin
          ext = u64_t'(w.half_x) * mag(plane_nx[k]) + u64_t'(w.half_y) * mag(plane_ny[k])
              + u64_t'(w.half_z) * mag(plane_nz[k]);
          // an extent past the signed range can never cull
          culled = (ext < 64'h8000_0000_0000_0000) && (d < -longint'(ext));
        end
      endcase
      if (culled) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic void apply_cull_word(fpct_pkg::in_word_t w);
    fpct_pkg::out_word_t o;
    if (w.cmd == fpct_pkg::CMD_LOAD) begin
      if (w.plane_slot < PLANES) begin
        plane_nx[w.plane_slot]  = w.vec_x;
        plane_ny[w.plane_slot]  = w.vec_y;
        plane_nz[w.plane_slot]  = w.vec_z;
        plane_off[w.plane_slot] = w.scalar_w;
      end
    end else begin
      o.visible   = object_visible(w);
      o.test_kind = w.cmd;
      visibility_q.push_back(o);
    end
  endfunction

  function automatic int rnd_sym(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic fpct_pkg::in_word_t load_word(int slot, int nx, int ny, int nz, int off);
    fpct_pkg::in_word_t w;
    w.cmd        = fpct_pkg::CMD_LOAD;
    w.plane_slot = 3'(slot);
    w.vec_x      = nx;
    w.vec_y      = ny;
    w.vec_z      = nz;
    w.scalar_w   = off;
    w.half_x     = 31'($urandom);
    w.half_y     = 31'($urandom);
    w.half_z     = 31'($urandom);
    return w;
  endfunction

  function automatic fpct_pkg::in_word_t test_word(logic [1:0] kind, int px, int py, int pz,
                                                   int r, int unsigned hx, int unsigned hy,
                                                   int unsigned hz);
    fpct_pkg::in_word_t w;
    w.cmd        = kind;
    w.plane_slot = 3'($urandom);
    w.vec_x      = px;
    w.vec_y      = py;
    w.vec_z      = pz;
    w.scalar_w   = r;
    w.half_x     = 31'(hx);
    w.half_y     = 31'(hy);
    w.half_z     = 31'(hz);
    return w;
  endfunction

  // driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left   = 0;
  int words_seen = 0;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && words_seen == words_in) begin
      // hold the stalled word
    end else begin
      words_seen = words_in;
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (scene_q.size() == 0) begin
        item_valid <= 1'b0;
      end else begin
        item_valid <= 1'b1;
        item       <= scene_q[0];
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  mode_left = 0;
  int  stall_pct = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && words_in >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: accept words, predict, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        apply_cull_word(item);
        void'(scene_q.pop_front());
        words_in++;
      end
      if (result_valid && !result_stall) begin
        if (visibility_q.size() == 0) begin
          $display("%0t: unexpected result, actual visible %0d kind %0d",
                   $time, result.visible, result.test_kind);
          mismatches++;
        end else begin
          if (result.visible !== visibility_q[0].visible) begin
            $display("%0t: visible expected %0d actual %0d (kind %0d)",
                     $time, visibility_q[0].visible, result.visible, visibility_q[0].test_kind);
            mismatches++;
          end
          if (result.test_kind !== visibility_q[0].test_kind) begin
            $display("%0t: test_kind expected %0d actual %0d",
                     $time, visibility_q[0].test_kind, result.test_kind);
            mismatches++;
          end
          void'(visibility_q.pop_front());
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    fpct_pkg::in_word_t w;
    int       n;
    int       s;
    int       pick;

    // untouched planes are all zero and never cull a point or a box
    scene_q.push_back(test_word(fpct_pkg::CMD_POINT, 0, 0, 0, $urandom, $urandom, $urandom,
                                $urandom));
    scene_q.push_back(test_word(fpct_pkg::CMD_BOX, VMIN, VMIN, VMIN, $urandom, HMAX, HMAX,
                                HMAX));
    // x >= 0 half space, probe the boundaries
    scene_q.push_back(load_word(0, ONE, 0, 0, 0));
    scene_q.push_back(test_word(fpct_pkg::CMD_POINT, -ONE, 0, 0, $urandom, $urandom, $urandom,
                                $urandom));
    scene_q.push_back(test_word(fpct_pkg::CMD_POINT, 0, 0, 0, $urandom, $urandom, $urandom,
                                $urandom));
    scene_q.push_back(test_word(fpct_pkg::CMD_SPHERE, -ONE, 0, 0, ONE, $urandom, $urandom,
                                $urandom));
    scene_q.push_back(test_word(fpct_pkg::CMD_SPHERE, -ONE - 1, 0, 0, ONE, $urandom, $urandom,
                                $urandom));
    scene_q.push_back(test_word(fpct_pkg::CMD_SPHERE, 0, 0, 0, -1, $urandom, $urandom,
                                $urandom));
    scene_q.push_back(test_word(fpct_pkg::CMD_BOX, -2 * ONE, 0, 0, $urandom, 2 * ONE, 0, 0));
    scene_q.push_back(test_word(fpct_pkg::CMD_BOX, -2 * ONE, 0, 0, $urandom, ONE, $urandom,
                                $urandom));
    // out-of-range slots must leave the table alone
    scene_q.push_back(load_word(6, -ONE, 0, 0, -100 * ONE));
    scene_q.push_back(load_word(7, -ONE, 0, 0, -100 * ONE));
    scene_q.push_back(test_word(fpct_pkg::CMD_POINT, 0, 0, 0, $urandom, $urandom, $urandom,
                                $urandom));
    // extreme planes: huge extents and wrapping distances
    scene_q.push_back(load_word(1, VMIN, VMIN, VMIN, VMAX));
    scene_q.push_back(test_word(fpct_pkg::CMD_BOX, 0, 0, 0, $urandom, HMAX, HMAX, HMAX));
    scene_q.push_back(test_word(fpct_pkg::CMD_POINT, VMAX, VMAX, VMAX, $urandom, 0, 0, 0));
    scene_q.push_back(test_word(fpct_pkg::CMD_POINT, VMIN, VMIN, VMIN, $urandom, 0, 0, 0));
    scene_q.push_back(load_word(5, VMAX, VMAX, VMAX, VMIN));
    scene_q.push_back(test_word(fpct_pkg::CMD_SPHERE, VMIN, VMIN, VMIN, VMIN, 0, 0, 0));
    scene_q.push_back(test_word(fpct_pkg::CMD_SPHERE, VMAX, VMAX, VMAX, VMAX, 0, 0, 0));
    // restore a sane cube, +-64 on each axis
    for (s = 0; s < PLANES; s++)
      scene_q.push_back(load_word(s, (s / 2 == 0) ? ((s % 2) ? -ONE : ONE) : 0,
                                  (s / 2 == 1) ? ((s % 2) ? -ONE : ONE) : 0,
                                  (s / 2 == 2) ? ((s % 2) ? -ONE : ONE) : 0, 64 * ONE));

    for (n = 0; n < 660; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // raw noise so that every bit toggles
        w.cmd        = 2'($urandom_range(0, 3));
        w.plane_slot = 3'($urandom);
        w.vec_x      = $urandom;
        w.vec_y      = $urandom;
        w.vec_z      = $urandom;
        w.scalar_w   = $urandom;
        w.half_x     = 31'($urandom);
        w.half_y     = 31'($urandom);
        w.half_z     = 31'($urandom);
        scene_q.push_back(w);
      end else if (pick < 10) begin
        for (s = 0; s < PLANES; s++)
          scene_q.push_back(load_word(s, rnd_sym(ONE), rnd_sym(ONE), rnd_sym(ONE),
                                      rnd_sym(64 * ONE)));
      end else if (pick < 24) begin
        scene_q.push_back(load_word($urandom_range(0, 7), rnd_sym(ONE), rnd_sym(ONE),
                                    rnd_sym(ONE), rnd_sym(64 * ONE)));
      end else begin
        scene_q.push_back(test_word(2'($urandom_range(1, 3)), rnd_sym(128 * ONE),
                                    rnd_sym(128 * ONE), rnd_sym(128 * ONE),
                                    int'($urandom_range(0, 40 * ONE)) - 8 * ONE,
                                    $urandom_range(0, 48 * ONE), $urandom_range(0, 48 * ONE),
                                    $urandom_range(0, 48 * ONE)));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (scene_q.size() != 0 || visibility_q.size() != 0) @(negedge clk);
    // let a trailing test drain before the verdict
    repeat (TAIL) @(negedge clk);

    if (mismatches == 0 && visibility_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
